[rtl/brace_nesting_tracker_core_defines.svh]
// Assertion macros used by the checker file of the brace nesting tracker.
`ifndef BRACE_NESTING_TRACKER_CORE_DEFINES_SVH
`define BRACE_NESTING_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BNT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BNT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bnt_pkg.sv]
// Package with types, character codes and constants of the brace nesting tracker.
package bnt_pkg;

    localparam int LINE_BITS       = 20;
    localparam int INDEX_BITS      = 16;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [1:0] {
        KIND_LINE  = 2'd0,
        KIND_PAIR  = 2'd1,
        KIND_UNBAL = 2'd2,
        KIND_OVFL  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] char_code;
        logic       first_of_file;
    } t_in;

    typedef struct packed {
        t_kind                 kind;
        logic [LINE_BITS-1:0]  line_number;
        logic [INDEX_BITS-1:0] brace_index;
        logic [LINE_BITS-1:0]  open_line;
        logic [LINE_BITS-1:0]  close_line;
    } t_out;

    // One stack entry: brace sequence index and its opening line.
    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic [LINE_BITS-1:0]  line;
    } t_entry;

    // Events found by the lexer for the byte at hand.
    typedef struct packed {
        logic newline;
        logic open;
        logic close;
    } t_lex_ev;

    // Shift controls common to every stack cell.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

[rtl/bnt_lexer.sv]
// Lexer that tracks comments, literals, escapes and the line counter.
module bnt_lexer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  bnt_pkg::t_in                  i_data,
    output bnt_pkg::t_lex_ev              o_ev,
    output logic [bnt_pkg::LINE_BITS-1:0] o_line
);

    typedef struct packed {
        logic blk;
        logic lcom;
        logic chr;
        logic str;
        logic slash;
        logic star;
        logic esc;
    } t_lex_state;

    t_lex_state                    r_st;
    t_lex_state                    n_st;
    t_lex_state                    cur;
    logic [bnt_pkg::LINE_BITS-1:0] r_line;
    logic [bnt_pkg::LINE_BITS-1:0] n_line;
    logic [bnt_pkg::LINE_BITS-1:0] base_line;
    logic [7:0]                    c;
    logic                          done;

    always_comb begin
        c         = i_data.char_code;
        cur       = i_data.first_of_file ? '0 : r_st;
        base_line = i_data.first_of_file ? bnt_pkg::LINE_BITS'(1) : r_line;
        n_st      = cur;
        o_ev      = '0;
        done      = 1'b0;
        n_line    = (c == bnt_pkg::CH_NL && base_line != '1) ?
                    base_line + bnt_pkg::LINE_BITS'(1) : base_line;

        // The byte after a backslash in a literal is skipped.
        if (cur.esc) begin
            n_st.esc = 1'b0;
            done     = 1'b1;
        end
        if (!done && cur.lcom) begin
            if (c != bnt_pkg::CH_NL) begin
                done = 1'b1;
            end else begin
                n_st.lcom = 1'b0;
            end
        end
        if (!done && cur.blk) begin
            n_st.star = 1'b0;
            if (cur.star && c == bnt_pkg::CH_SLASH) begin
                n_st.blk = 1'b0;
            end else if (c == bnt_pkg::CH_STAR) begin
                n_st.star = 1'b1;
            end
            done = 1'b1;
        end
        if (!done && cur.slash) begin
            n_st.slash = 1'b0;
            if (c == bnt_pkg::CH_SLASH) begin
                n_st.lcom = 1'b1;
                done      = 1'b1;
            end else if (c == bnt_pkg::CH_STAR) begin
                n_st.blk = 1'b1;
                done     = 1'b1;
            end
        end
        if (!done && (cur.chr || cur.str)) begin
            if (c == bnt_pkg::CH_BSLASH) begin
                n_st.esc = 1'b1;
            end else begin
                if (c == bnt_pkg::CH_QUOTE && !cur.str) begin
                    n_st.chr = 1'b0;
                end
                if (c == bnt_pkg::CH_DQUOTE && !cur.chr) begin
                    n_st.str = 1'b0;
                end
            end
            done = 1'b1;
        end
        if (!done) begin
            case (c)
                bnt_pkg::CH_SLASH:  n_st.slash = 1'b1;
                bnt_pkg::CH_QUOTE:  n_st.chr = 1'b1;
                bnt_pkg::CH_DQUOTE: n_st.str = 1'b1;
                bnt_pkg::CH_NL:     o_ev.newline = 1'b1;
                bnt_pkg::CH_LBRACE: o_ev.open = 1'b1;
                bnt_pkg::CH_RBRACE: o_ev.close = 1'b1;
                default: ;
            endcase
        end
        o_line = n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= '0;
            r_line <= bnt_pkg::LINE_BITS'(1);
        end else if (i_accept) begin
            r_st   <= n_st;
            r_line <= n_line;
        end
    end

endmodule

[rtl/bnt_stack_cell.sv]
// One cell of the shifting brace stack; cell zero holds the innermost brace.
module bnt_stack_cell (
    input  logic               i_clk,
    input  bnt_pkg::t_cell_ctl i_ctl,
    input  bnt_pkg::t_entry    i_above,
    input  bnt_pkg::t_entry    i_below,
    output bnt_pkg::t_entry    o_entry
);

    bnt_pkg::t_entry r_entry;

    // A push moves entries one cell deeper, a pop moves them one cell up.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_above;
        end else if (i_ctl.pop) begin
            r_entry <= i_below;
        end
    end

    assign o_entry = r_entry;

endmodule

[rtl/brace_nesting_tracker_core.sv]
// A result is registered into o_valid/o_data, or into the skid register while the output is held.
// Throughput: one byte per cycle when o_stall is low; lexer and stack shift keep pace.
// o_stall rises only when both the output register and the skid register are full.
// Reset (i_rst_n low, synchronous) clears lexer state, counters, stack depth and
// output valid flags; stack cell contents are left as they are and never read empty.
module brace_nesting_tracker_core #(
    parameter int STACK_DEPTH = bnt_pkg::STACK_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  bnt_pkg::t_in i_data,
    output logic         o_valid,
    input  logic         i_stall,
    output bnt_pkg::t_out o_data
);

    // The stack depth counter must hold STACK_DEPTH itself for the full check.
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
    localparam int BC_W = bnt_pkg::INDEX_BITS + 1;

    logic                           in_accept;
    logic                           out_taken;
    bnt_pkg::t_lex_ev               lex_ev;
    logic [bnt_pkg::LINE_BITS-1:0]  lex_line;

    // Stack depth and count of braces opened so far.
    logic [SP_W-1:0]                r_sp;
    logic [SP_W-1:0]                n_sp;
    logic [SP_W-1:0]                cur_sp;
    logic [BC_W-1:0]                r_bc;
    logic [BC_W-1:0]                n_bc;
    logic [BC_W-1:0]                cur_bc;

    bnt_pkg::t_cell_ctl             cell_ctl;
    bnt_pkg::t_entry                push_entry;
    bnt_pkg::t_entry                w_cell [STACK_DEPTH];

    logic                           res_valid;
    bnt_pkg::t_out                  res;

    // Output register plus one skid register, so a new transaction is taken
    // while a finished result still waits downstream.
    logic                           r_out_valid;
    bnt_pkg::t_out                  r_out;
    logic                           r_skid_valid;
    bnt_pkg::t_out                  r_skid;

    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;
    assign out_taken = r_out_valid && !i_stall;

    bnt_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_data   (i_data),
        .o_ev     (lex_ev),
        .o_line   (lex_line)
    );

    // The stack is a chain of cells. Cell zero is always the innermost open
    // brace, so every read of the stack looks at a fixed place and every
    // push or pop is one shift of the whole chain.
    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        bnt_pkg::t_entry above;
        bnt_pkg::t_entry below;

        if (k == 0) begin : g_first
            assign above = push_entry;
        end else begin : g_mid_above
            assign above = w_cell[k-1];
        end

        if (k == STACK_DEPTH - 1) begin : g_last
            assign below = w_cell[k];
        end else begin : g_mid_below
            assign below = w_cell[k+1];
        end

        bnt_stack_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_above (above),
            .i_below (below),
            .o_entry (w_cell[k])
        );
    end

    // Brace handling for the accepted byte. The start-of-file flag makes the
    // counters read as their reset values for this byte.
    always_comb begin
        cur_sp           = i_data.first_of_file ? '0 : r_sp;
        cur_bc           = i_data.first_of_file ? '0 : r_bc;
        n_sp             = cur_sp;
        n_bc             = cur_bc;
        cell_ctl         = '0;
        push_entry.index = cur_bc[bnt_pkg::INDEX_BITS-1:0];
        push_entry.line  = lex_line;
        res_valid        = 1'b0;
        res.kind         = bnt_pkg::KIND_LINE;
        res.line_number  = lex_line;
        res.brace_index  = '0;
        res.open_line    = '0;
        res.close_line   = '0;

        if (lex_ev.newline) begin
            // A newline inside an open brace reports the innermost brace.
            if (cur_sp != '0) begin
                res_valid       = 1'b1;
                res.kind        = bnt_pkg::KIND_LINE;
                res.brace_index = w_cell[0].index;
                res.open_line   = w_cell[0].line;
            end
        end else if (lex_ev.open) begin
            // The top bit of the brace count marks an exhausted index space.
            if (cur_bc[BC_W-1] || cur_sp == SP_FULL) begin
                res_valid = 1'b1;
                res.kind  = bnt_pkg::KIND_OVFL;
            end else begin
                cell_ctl.push = 1'b1;
                n_sp          = cur_sp + SP_W'(1);
                n_bc          = cur_bc + BC_W'(1);
            end
        end else if (lex_ev.close) begin
            res_valid = 1'b1;
            if (cur_sp == '0) begin
                res.kind = bnt_pkg::KIND_UNBAL;
            end else begin
                cell_ctl.pop    = 1'b1;
                n_sp            = cur_sp - SP_W'(1);
                res.kind        = bnt_pkg::KIND_PAIR;
                res.brace_index = w_cell[0].index;
                res.open_line   = w_cell[0].line;
                res.close_line  = lex_line;
            end
        end

        // The stack only shifts for an accepted transaction.
        if (!in_accept) begin
            cell_ctl  = '0;
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
            r_bc <= '0;
        end else if (in_accept) begin
            r_sp <= n_sp;
            r_bc <= n_bc;
        end
    end

    // While the skid register is full nothing is accepted, so it only drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_taken) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_taken) begin
            r_out_valid <= res_valid;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_taken) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_taken) begin
            r_out <= res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[rtl/bnt_checker.sv]
// Port-level assertion checker for the brace nesting tracker, bound to the top level.
`include "brace_nesting_tracker_core_defines.svh"

module bnt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input bnt_pkg::t_out o_data
);

    logic out_held;
    logic pair_out;
    logic close_match;
    logic err_out;
    logic err_clear;

    assign out_held    = o_valid && i_stall;
    assign pair_out    = o_valid && o_data.kind == bnt_pkg::KIND_PAIR;
    assign close_match = o_data.close_line == o_data.line_number;
    assign err_out     = o_valid && (o_data.kind == bnt_pkg::KIND_UNBAL ||
                                     o_data.kind == bnt_pkg::KIND_OVFL);
    assign err_clear   = o_data.brace_index == '0 && o_data.open_line == '0 &&
                         o_data.close_line == '0;

    `BNT_ASSERT_NEXT(a_out_hold, out_held, o_valid && $stable(o_data), "result changed under stall")
    `BNT_ASSERT_NOW(a_stall_needs_out, o_stall, o_valid, "input stalled with no result waiting")
    `BNT_ASSERT_NOW(a_pair_close_line, pair_out, close_match, "closing line differs")
    `BNT_ASSERT_NOW(a_error_fields_zero, err_out, err_clear, "error transaction carries brace data")

endmodule

bind brace_nesting_tracker_core bnt_checker u_bnt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

[tb/testbench.sv]
// Self-checking testbench for the brace nesting tracker core, with its own tracker model.
module testbench;
    import bnt_pkg::*;

    localparam int                    DEPTH       = STACK_DEPTH_DEF;
    localparam logic [LINE_BITS-1:0]  LINE_TOP    = '1;
    localparam logic [INDEX_BITS:0]   SEQ_LIMIT   = {1'b1, {INDEX_BITS{1'b0}}};
    localparam int                    MAX_REPORTS = 100;
    localparam int                    IDLE_PCT    = 24;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_in   i_data;
    logic  o_valid;
    logic  i_stall = 1'b0;
    t_out  o_data;

    brace_nesting_tracker_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Tracker state kept by the testbench.
    logic                  in_block, in_line_cmt, in_char, in_str;
    logic                  slash_held, star_held, esc_held;
    logic [LINE_BITS-1:0]  line_no;
    logic [INDEX_BITS:0]   brace_seq;
    int                    depth;
    logic [INDEX_BITS-1:0] open_idx [DEPTH];
    logic [LINE_BITS-1:0]  open_ln  [DEPTH];

    t_out  expected_records [$];
    int    mismatches;
    int    items_sent;
    bit    tx_idle_en;
    bit    rx_idle_en;
    int    rx_hold_left;
    string filler = "abxyz019_ ;(),=+-";

    function automatic void clear_tracker();
        in_block    = 1'b0;
        in_line_cmt = 1'b0;
        in_char     = 1'b0;
        in_str      = 1'b0;
        slash_held  = 1'b0;
        star_held   = 1'b0;
        esc_held    = 1'b0;
        line_no     = LINE_BITS'(1);
        brace_seq   = '0;
        depth       = 0;
    endfunction

    // Advances the tracker by one byte; returns 1 when the byte yields a record.
    function automatic bit track_byte(input logic [7:0] ch, input logic first,
                                      output t_out rec);
        bit star;
        rec = '0;
        if (first)
            clear_tracker();
        // Newlines count everywhere, even right after a backslash in a literal.
        if (ch == CH_NL && line_no != LINE_TOP)
            line_no++;
        if (esc_held) begin
            esc_held = 1'b0;
            return 0;
        end
        if (in_line_cmt) begin
            if (ch != CH_NL)
                return 0;
            in_line_cmt = 1'b0;
        end
        if (in_block) begin
            star      = star_held;
            star_held = 1'b0;
            if (star && ch == CH_SLASH)
                in_block = 1'b0;
            else if (ch == CH_STAR)
                star_held = 1'b1;
            return 0;
        end
        // A held slash opens a comment only when the next byte is a slash or star.
        if (slash_held) begin
            slash_held = 1'b0;
            if (ch == CH_SLASH) begin
                in_line_cmt = 1'b1;
                return 0;
            end
            if (ch == CH_STAR) begin
                in_block = 1'b1;
                return 0;
            end
        end
        if (in_char || in_str) begin
            if (ch == CH_BSLASH)
                esc_held = 1'b1;
            else if (ch == CH_QUOTE && !in_str)
                in_char = 1'b0;
            else if (ch == CH_DQUOTE && !in_char)
                in_str = 1'b0;
            return 0;
        end
        rec.line_number = line_no;
        case (ch)
            CH_SLASH:  slash_held = 1'b1;
            CH_QUOTE:  in_char = 1'b1;
            CH_DQUOTE: in_str = 1'b1;
            CH_NL: begin
                if (depth > 0) begin
                    rec.kind        = KIND_LINE;
                    rec.brace_index = open_idx[depth-1];
                    rec.open_line   = open_ln[depth-1];
                    return 1;
                end
            end
            CH_LBRACE: begin
                // A full stack or spent index range drops the brace.
                if (brace_seq >= SEQ_LIMIT || depth >= DEPTH) begin
                    rec.kind = KIND_OVFL;
                    return 1;
                end
                open_idx[depth] = brace_seq[INDEX_BITS-1:0];
                open_ln[depth]  = line_no;
                depth++;
                brace_seq++;
            end
            CH_RBRACE: begin
                if (depth == 0) begin
                    rec.kind = KIND_UNBAL;
                    return 1;
                end
                depth--;
                rec.kind        = KIND_PAIR;
                rec.brace_index = open_idx[depth];
                rec.open_line   = open_ln[depth];
                rec.close_line  = line_no;
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Checks each delivered record, then predicts from the transaction taken at this edge.
    always @(posedge i_clk) begin : check_and_predict
        t_out want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_records.size() == 0) begin
                    report_mismatch("record with nothing expected, kind",
                                    32'(o_data.kind), 32'd0);
                end else begin
                    want = expected_records.pop_front();
                    if (o_data.kind != want.kind)
                        report_mismatch("kind", 32'(o_data.kind), 32'(want.kind));
                    if (o_data.line_number != want.line_number)
                        report_mismatch("line_number", 32'(o_data.line_number),
                                        32'(want.line_number));
                    if (o_data.brace_index != want.brace_index)
                        report_mismatch("brace_index", 32'(o_data.brace_index),
                                        32'(want.brace_index));
                    if (o_data.open_line != want.open_line)
                        report_mismatch("open_line", 32'(o_data.open_line),
                                        32'(want.open_line));
                    if (o_data.close_line != want.close_line)
                        report_mismatch("close_line", 32'(o_data.close_line),
                                        32'(want.close_line));
                end
            end
            if (i_valid && !o_stall) begin
                if (track_byte(i_data.char_code, i_data.first_of_file, want))
                    expected_records.insert(expected_records.size(), want);
            end
        end
    end

    // Receiver side: a requested hold-off first, otherwise random stalls.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_stall <= 1'b1;
            rx_hold_left--;
        end else begin
            i_stall <= rx_idle_en && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Offers one byte and returns at the falling edge after it was taken.
    task automatic send_byte(input logic [7:0] ch, input logic first = 1'b0);
        while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= t_in'{char_code: ch, first_of_file: first};
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Content byte for comments and literals, biased toward the interesting characters.
    function automatic logic [7:0] text_byte();
        case ($urandom_range(11))
            0:       return CH_LBRACE;
            1:       return CH_RBRACE;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_NL;
            5:       return CH_QUOTE;
            default: return filler[$urandom_range(filler.len() - 1)];
        endcase
    endfunction

    // Line, pair and unbalanced records plus comments, literals, escapes and the byte extremes.
    task automatic test_directed_lexing();
        logic [7:0] text [$];
        text = '{CH_LBRACE, CH_NL, CH_RBRACE, CH_RBRACE,
                 CH_LBRACE, CH_SLASH, CH_SLASH, CH_RBRACE, CH_NL,
                 CH_SLASH, CH_STAR, CH_LBRACE, CH_STAR, CH_STAR, CH_SLASH,
                 CH_SLASH, CH_LBRACE,
                 CH_DQUOTE, CH_BSLASH, CH_NL, CH_SLASH, CH_STAR, CH_DQUOTE,
                 CH_QUOTE, CH_DQUOTE, CH_QUOTE,
                 8'hFF, 8'h00, CH_NL, CH_RBRACE, CH_RBRACE};
        foreach (text[i])
            send_byte(text[i], i == 0);
    endtask

    // A restart inside an open string with braces open leaves an empty stack.
    task automatic test_restart();
        send_byte(CH_LBRACE, 1'b1);
        send_byte(CH_LBRACE);
        send_byte(CH_DQUOTE);
        send_byte(CH_RBRACE, 1'b1);
        send_byte(CH_NL);
    endtask

    task automatic test_stack_full();
        send_byte(CH_LBRACE, 1'b1);
        repeat (DEPTH) send_byte(CH_LBRACE);
        send_byte(CH_NL);
        repeat (DEPTH) send_byte(CH_RBRACE);
        send_byte(CH_RBRACE);
    endtask

    // The receiver holds off long enough that both output registers fill.
    task automatic test_output_backpressure();
        rx_hold_left = 60;
        send_byte(CH_RBRACE, 1'b1);
        repeat (19) send_byte(CH_RBRACE);
    endtask

    // Mostly well-formed C-like tokens with random content, plus raw noise and restarts.
    task automatic test_random_text(input int goal);
        int pick;
        goal += items_sent;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                send_byte(depth < 24 ? CH_LBRACE : CH_RBRACE);
            end else if (pick < 28) begin
                send_byte((depth > 0 || pick < 18) ? CH_RBRACE : CH_LBRACE);
            end else if (pick < 44) begin
                send_byte(CH_NL);
            end else if (pick < 58) begin
                repeat ($urandom_range(1, 6))
                    send_byte(filler[$urandom_range(filler.len() - 1)]);
            end else if (pick < 65) begin
                send_byte(CH_SLASH);
                send_byte(CH_SLASH);
                repeat ($urandom_range(5)) send_byte(text_byte());
                send_byte(CH_NL);
            end else if (pick < 72) begin
                send_byte(CH_SLASH);
                send_byte(CH_STAR);
                repeat ($urandom_range(6)) send_byte(text_byte());
                send_byte(CH_STAR);
                send_byte(CH_SLASH);
            end else if (pick < 80) begin
                send_byte(CH_DQUOTE);
                repeat ($urandom_range(5)) begin
                    if ($urandom_range(3) == 0) begin
                        send_byte(CH_BSLASH);
                        send_byte($urandom_range(1) ? CH_DQUOTE : text_byte());
                    end else begin
                        send_byte(text_byte());
                    end
                end
                send_byte(CH_DQUOTE);
            end else if (pick < 85) begin
                send_byte(CH_QUOTE);
                if ($urandom_range(1)) begin
                    send_byte(CH_BSLASH);
                    send_byte($urandom_range(1) ? CH_QUOTE : text_byte());
                end else begin
                    send_byte(text_byte());
                end
                send_byte(CH_QUOTE);
            end else if (pick < 97) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(8'($urandom_range(255)), 1'b1);
            end
        end
    endtask

    // Both sides run with no idling at all for a stretch of random text.
    task automatic test_no_idle_stretch();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_text(300);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        rx_hold_left = 0;
        mismatches   = 0;
        items_sent   = 0;
        clear_tracker();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_lexing();
        test_restart();
        test_stack_full();
        test_output_backpressure();
        test_no_idle_stretch();
        test_random_text(1600 - items_sent);
        i_valid <= 1'b0;

        // Let the last records drain, with a bound in case the block hangs.
        for (int n = 0; n < 2000 && expected_records.size() != 0; n++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (expected_records.size() != 0)
            report_mismatch("records never delivered", 32'd0,
                            32'(expected_records.size()));

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Hard stop well beyond the slowest legitimate run.
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[brace_nesting_tracker_core.f]
+incdir+rtl
rtl/bnt_pkg.sv
rtl/bnt_lexer.sv
rtl/bnt_stack_cell.sv
rtl/brace_nesting_tracker_core.sv
rtl/bnt_checker.sv
tb/testbench.sv
